FILE: src/lrpf_pkg.sv
// Shared types and constants for the line raster page frame buffer.
package lrpf_pkg;

    localparam int DEF_WIDTH = 128;
    localparam int DEF_PAGES = 8;

    localparam int XW   = 7;   // column field width
    localparam int YW   = 6;   // row field width
    localparam int PW   = 3;   // page field width
    localparam int DW   = 8;   // stored byte width
    localparam int CW   = 8;   // pixel count width
    localparam int LW   = 7;   // major-axis length width
    localparam int ERRW = 10;  // signed Bresenham error term

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINE,
        S_DRAIN,
        S_READ,
        S_CAPT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    step;
        logic    clr_step;
        logic    rd_capture;
        logic    out_load;
        t_opcode out_sel;
    } t_cmd;

    typedef struct packed {
        logic last_pixel;
        logic clr_last;
    } t_sts;

endpackage

FILE: src/line_raster_page_framebuffer.sv
// Top level of the line raster page frame buffer: controller plus datapath.
// A page-organised monochrome frame store of PAGES x WIDTH bytes, eight vertical
// pixels to a byte. After reset the store is swept to zero, one byte a cycle;
// o_in_ready stays low until the sweep is done. A draw transaction loads its
// set-up, steps through the line's pixels (the major-axis length plus one),
// drains the last write and loads the result; the stepping rate is set by the
// frame store, which gives one read and one write a cycle, with the previous
// write forwarded when successive pixels share a byte. A read transaction loads
// its address, reads the store, captures the byte and loads the result; a clear
// transaction sweeps the whole store and loads its result. One transaction is
// worked at a time; a finished result waits in the output register while the
// next transaction is accepted. Every transaction yields exactly one result.
module line_raster_page_framebuffer
    import lrpf_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH,
    parameter int PAGES = DEF_PAGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_opcode,
    input  logic [XW-1:0] i_start_x,
    input  logic [YW-1:0] i_start_y,
    input  logic [XW-1:0] i_end_x,
    input  logic [YW-1:0] i_end_y,
    input  logic          i_erase,
    input  logic [PW-1:0] i_read_page,
    input  logic [XW-1:0] i_read_column,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [DW-1:0] o_read_data,
    output logic [CW-1:0] o_pixels_drawn
);

    t_cmd cmd;
    t_sts sts;

    lrpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lrpf_datapath #(
        .WIDTH (WIDTH),
        .PAGES (PAGES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_erase        (i_erase),
        .i_read_page    (i_read_page),
        .i_read_column  (i_read_column),
        .o_read_data    (o_read_data),
        .o_pixels_drawn (o_pixels_drawn)
    );

endmodule

FILE: src/lrpf_ctrl.sv
// Controller state machine: sequences clear sweeps, line steps, reads and results.
module lrpf_ctrl
    import lrpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_cmd       o_cmd,
    input  t_sts       i_sts
);

    t_state  r_state, n_state;
    t_opcode r_op, n_op;
    logic    r_clr_cmd, n_clr_cmd;
    logic    r_out_valid, n_out_valid;
    t_cmd    cmd;
    logic    in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_op        <= OP_DRAW;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_clr_cmd   = r_clr_cmd;
        cmd         = '0;
        cmd.out_sel = r_op;
        in_ready    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load  = 1'b1;
                    n_op      = t_opcode'(i_opcode);
                    n_clr_cmd = 1'b0;
                    case (t_opcode'(i_opcode))
                        OP_DRAW:  n_state = S_LINE;
                        OP_READ:  n_state = S_READ;
                        OP_CLEAR: begin
                            n_state   = S_CLEAR;
                            n_clr_cmd = 1'b1;
                        end
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_LINE: begin
                cmd.step = 1'b1;
                if (i_sts.last_pixel) begin
                    n_state = S_DRAIN;
                end
            end
            // let the final read-modify-write retire
            S_DRAIN: n_state = S_DONE;
            S_READ:  n_state = S_CAPT;
            S_CAPT: begin
                cmd.rd_capture = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = cmd.out_load | (r_out_valid & ~i_out_ready);
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == S_CLEAR)
        else $error("clear sweep does not follow reset");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_drain_after_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> ($past(r_state) == S_LINE))
        else $error("drain entered without a line");

endmodule

FILE: src/lrpf_datapath.sv
// Datapath: Bresenham stepper, frame store with read-modify-write, clear sweep, result register.
module lrpf_datapath
    import lrpf_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH,
    parameter int PAGES = DEF_PAGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic [XW-1:0] i_start_x,
    input  logic [YW-1:0] i_start_y,
    input  logic [XW-1:0] i_end_x,
    input  logic [YW-1:0] i_end_y,
    input  logic          i_erase,
    input  logic [PW-1:0] i_read_page,
    input  logic [XW-1:0] i_read_column,
    output logic [DW-1:0] o_read_data,
    output logic [CW-1:0] o_pixels_drawn
);

    localparam int DEPTH = PAGES * WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_mem_q;

    logic                   r_flip;
    logic [AW-1:0]          r_clr_addr;
    logic [XW-1:0]          r_x;
    logic [YW-1:0]          r_y;
    logic [LW-1:0]          r_dx, r_dy, r_left;
    logic                   r_sxn, r_syn, r_xmaj, r_erase;
    logic signed [ERRW-1:0] r_err;
    logic [CW-1:0]          r_count;
    logic [PW-1:0]          r_rp;
    logic [XW-1:0]          r_rc;
    logic                   r_b_valid;
    logic [AW-1:0]          r_b_addr;
    logic [2:0]             r_b_bit;
    logic                   r_fwd_valid;
    logic [AW-1:0]          r_fwd_addr;
    logic [DW-1:0]          r_fwd_data;
    logic [DW-1:0]          r_rd_data;
    logic [DW-1:0]          r_out_rd;
    logic [CW-1:0]          r_out_cnt;

    // load-time line set-up
    logic                   ld_sxn, ld_syn, ld_xmaj;
    logic [LW-1:0]          ld_dx;
    logic [LW-1:0]          ld_dy;
    logic [LW-1:0]          ld_len;

    assign ld_sxn  = !(i_end_x > i_start_x);
    assign ld_syn  = !(i_end_y > i_start_y);
    assign ld_dx   = ld_sxn ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
    assign ld_dy   = ld_syn ? LW'(i_start_y - i_end_y) : LW'(i_end_y - i_start_y);
    assign ld_xmaj = ld_dx > ld_dy;
    assign ld_len  = ld_xmaj ? ld_dx : ld_dy;

    // one Bresenham step
    logic signed [ERRW-1:0] dx2, dy2, e1, e2;
    logic                   minor;
    logic [XW-1:0]          xs, n_x;
    logic [YW-1:0]          ys, n_y;

    assign dx2   = $signed({2'b00, r_dx, 1'b0});
    assign dy2   = $signed({2'b00, r_dy, 1'b0});
    assign e1    = r_err + (r_xmaj ? dy2 : dx2);
    assign minor = ~e1[ERRW-1];
    assign e2    = minor ? (e1 - (r_xmaj ? dx2 : dy2)) : e1;
    assign xs    = r_sxn ? (r_x - XW'(1)) : (r_x + XW'(1));
    assign ys    = r_syn ? (r_y - YW'(1)) : (r_y + YW'(1));
    assign n_x   = (r_xmaj || minor) ? xs : r_x;
    assign n_y   = (!r_xmaj || minor) ? ys : r_y;

    // pixel and read addressing
    logic [PW-1:0] pix_page;
    logic          pix_in;
    logic [AW-1:0] pix_addr;
    logic          rd_ok;
    logic [AW-1:0] rd_cmd_addr;
    logic [AW-1:0] rd_addr;

    assign pix_page    = r_y[YW-1:3];
    assign pix_in      = (int'(pix_page) < PAGES) && (int'(r_x) < WIDTH);
    assign pix_addr    = AW'(int'(pix_page) * WIDTH + int'(r_x));
    assign rd_ok       = (int'(r_rp) < PAGES) && (int'(r_rc) < WIDTH);
    assign rd_cmd_addr = AW'(int'(r_rp) * WIDTH + int'(r_rc));
    assign rd_addr     = i_cmd.step ? pix_addr : rd_cmd_addr;

    // byte update, forwarding the write that lands on the same edge as the read
    logic [DW-1:0] cur, mask, upd, rev, fin;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          clr_last;

    assign cur      = (r_fwd_valid && (r_fwd_addr == r_b_addr)) ? r_fwd_data : r_mem_q;
    assign mask     = 8'h01 << r_b_bit;
    assign upd      = r_erase ? (cur & ~mask) : (cur | mask);
    assign rev      = {<<{upd}};
    assign fin      = r_flip ? rev : upd;
    assign we       = i_cmd.clr_step | r_b_valid;
    assign wr_addr  = i_cmd.clr_step ? r_clr_addr : r_b_addr;
    assign wr_data  = i_cmd.clr_step ? '0 : fin;
    assign clr_last = (r_clr_addr == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip      <= 1'b0;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_flip <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= clr_last ? '0 : (r_clr_addr + AW'(1));
            end
            r_b_valid   <= i_cmd.step && pix_in;
            r_fwd_valid <= we;
            if (i_cmd.load) begin
                r_count <= '0;
            end else if (i_cmd.step) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_addr   <= pix_addr;
        r_b_bit    <= r_y[2:0];
        r_fwd_addr <= wr_addr;
        r_fwd_data <= wr_data;
        if (i_cmd.load) begin
            r_x     <= i_start_x;
            r_y     <= i_start_y;
            r_dx    <= ld_dx;
            r_dy    <= ld_dy;
            r_sxn   <= ld_sxn;
            r_syn   <= ld_syn;
            r_xmaj  <= ld_xmaj;
            r_err   <= -$signed({3'b000, ld_len});
            r_left  <= ld_len;
            r_erase <= i_erase;
            r_rp    <= i_read_page;
            r_rc    <= i_read_column;
        end else if (i_cmd.step) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_err  <= e2;
            r_left <= r_left - LW'(1);
        end
        if (i_cmd.rd_capture) begin
            r_rd_data <= rd_ok ? r_mem_q : '0;
        end
        if (i_cmd.out_load) begin
            r_out_rd  <= (i_cmd.out_sel == OP_READ) ? r_rd_data : '0;
            r_out_cnt <= (i_cmd.out_sel == OP_DRAW) ? r_count : '0;
        end
    end

    assign o_sts.last_pixel = (r_left == '0);
    assign o_sts.clr_last   = clr_last;
    assign o_read_data      = r_out_rd;
    assign o_pixels_drawn   = r_out_cnt;

    a_rmw_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> $past(i_cmd.step))
        else $error("pixel write without a line step");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_step |-> !r_b_valid)
        else $error("clear sweep collides with a pixel write");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(128))
        else $error("pixel count beyond longest line");

endmodule

FILE: tb/line_raster_page_framebuffer_tb.sv
// Self-checking testbench for the line raster page frame buffer: line draws, reads and clears.
module line_raster_page_framebuffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrpf_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_PER_PHASE = 345;

    typedef struct packed {
        logic [1:0]    opcode;
        logic [XW-1:0] start_x;
        logic [YW-1:0] start_y;
        logic [XW-1:0] end_x;
        logic [YW-1:0] end_y;
        logic          erase;
        logic [PW-1:0] read_page;
        logic [XW-1:0] read_column;
    } t_item;

    typedef struct packed {
        logic [DW-1:0] read_data;
        logic [CW-1:0] pixels_drawn;
    } t_result;

    typedef struct packed {
        t_item   cmd;
        logic    typed;
        t_result want;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_data = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [1:0]    i_opcode = '0;
    logic [XW-1:0] i_start_x = '0;
    logic [YW-1:0] i_start_y = '0;
    logic [XW-1:0] i_end_x = '0;
    logic [YW-1:0] i_end_y = '0;
    logic          i_erase = 1'b0;
    logic [PW-1:0] i_read_page = '0;
    logic [XW-1:0] i_read_column = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [DW-1:0] o_read_data;
    logic [CW-1:0] o_pixels_drawn;

    logic [DW-1:0] shadow_store [DEF_PAGES][DEF_WIDTH];
    bit            flip_shadow;
    t_result       pending_results [$];
    t_result       oldest;
    int            mismatches = 0;
    int            stall_cycles = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            last_x = 0;
    int            last_y = 0;

    // Rows with a typed result are checked against it; the rest use the predictor.
    t_row directed_rows [22] = '{
        '{'{OP_READ,   0,   0,   0,   0,  0, 0,   0}, 1'b1, '{8'd0, 8'd0}},
        '{'{OP_READ,   127, 63,  127, 63, 1, 7, 127}, 1'b1, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   0,   0,   0,   0,  0, 0,   0}, 1'b1, '{8'd0, 8'd1}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 0,   0}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   0,   0,   127, 63, 0, 0,   0}, 1'b1, '{8'd0, 8'd128}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 4,  64}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   127, 63,  0,   0,  1, 0,   0}, 1'b1, '{8'd0, 8'd128}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 4,  64}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   5,   0,   5,   63, 0, 0,   0}, 1'b1, '{8'd0, 8'd64}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 3,   5}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_UNUSED, 127, 63,  127, 63, 1, 7, 127}, 1'b1, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   10,  63,  3,   0,  0, 0,   0}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   127, 0,   0,   63, 1, 0,   0}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 7,  10}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_CLEAR,  127, 63,  127, 63, 1, 7, 127}, 1'b1, '{8'd0, 8'd0}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 3,   5}, 1'b1, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   0,   63,  127, 63, 0, 0,   0}, 1'b1, '{8'd0, 8'd128}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 7, 127}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   3,   7,   4,   8,  0, 0,   0}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 1,   4}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_DRAW,   60,  30,  66,  33, 0, 0,   0}, 1'b0, '{8'd0, 8'd0}},
        '{'{OP_READ,   0,   0,   0,   0,  0, 3,  63}, 1'b0, '{8'd0, 8'd0}}
    };

    line_raster_page_framebuffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_erase       (i_erase),
        .i_read_page   (i_read_page),
        .i_read_column (i_read_column),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_pixels_drawn(o_pixels_drawn)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [DW-1:0] mirror_byte(logic [DW-1:0] v);
        logic [DW-1:0] r;
        for (int k = 0; k < DW; k++) r[k] = v[DW-1-k];
        return r;
    endfunction

    function automatic void set_pixel(int x, int y, bit clr);
        int pg;
        int bit_ix;
        logic [DW-1:0] b;
        pg = y / 8;
        bit_ix = y % 8;
        // off-store pixels still count but are not written
        if (x < 0 || y < 0 || pg >= DEF_PAGES || x >= DEF_WIDTH) return;
        b = shadow_store[pg][x];
        b[bit_ix] = !clr;
        if (flip_shadow) b = mirror_byte(b);
        shadow_store[pg][x] = b;
    endfunction

    function automatic int rasterise(int x, int y, int xe, int ye, bit clr);
        int dx, dy, sx, sy, err, steps, i;
        dx = (xe > x) ? xe - x : x - xe;
        dy = (ye > y) ? ye - y : y - ye;
        sx = (xe > x) ? 1 : -1;
        sy = (ye > y) ? 1 : -1;
        steps = 0;
        if (dx > dy) begin
            err = -dx;
            for (i = 0; i <= dx; i++) begin
                set_pixel(x, y, clr);
                steps++;
                x += sx;
                err += 2 * dy;
                if (err >= 0) begin
                    y += sy;
                    err -= 2 * dx;
                end
            end
        end else begin
            err = -dy;
            for (i = 0; i <= dy; i++) begin
                set_pixel(x, y, clr);
                steps++;
                y += sy;
                err += 2 * dx;
                if (err >= 0) begin
                    x += sx;
                    err -= 2 * dy;
                end
            end
        end
        return steps;
    endfunction

    function automatic t_result execute_page_cmd(t_item c);
        t_result r;
        r = '0;
        case (c.opcode)
            OP_DRAW: begin
                r.pixels_drawn = CW'(rasterise(int'(c.start_x), int'(c.start_y),
                                               int'(c.end_x), int'(c.end_y), c.erase));
            end
            OP_READ: begin
                r.read_data = shadow_store[c.read_page][c.read_column];
            end
            OP_CLEAR: begin
                foreach (shadow_store[p, q]) shadow_store[p][q] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int clamp_to(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic t_item random_cmd();
        t_item c;
        int pick;
        c.start_x     = XW'($urandom_range(0, DEF_WIDTH - 1));
        c.start_y     = YW'($urandom_range(0, 63));
        c.end_x       = XW'($urandom_range(0, DEF_WIDTH - 1));
        c.end_y       = YW'($urandom_range(0, 63));
        c.erase       = 1'($urandom_range(0, 1));
        c.read_page   = PW'($urandom_range(0, DEF_PAGES - 1));
        c.read_column = XW'($urandom_range(0, DEF_WIDTH - 1));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            c.opcode = OP_DRAW;
            // short lines make it likely that successive pixels share a byte
            if ($urandom_range(0, 2) == 0) begin
                c.end_x = XW'(clamp_to(int'(c.start_x) + int'($urandom_range(0, 8)) - 4,
                                       DEF_WIDTH - 1));
                c.end_y = YW'(clamp_to(int'(c.start_y) + int'($urandom_range(0, 8)) - 4, 63));
            end
            last_x = int'(c.start_x);
            last_y = int'(c.start_y);
        end else if (pick < 88) begin
            c.opcode = OP_READ;
            // aim half the reads at a byte the last line touched
            if ($urandom_range(0, 1) == 1) begin
                c.read_page   = PW'(last_y / 8);
                c.read_column = XW'(last_x);
            end
        end else if (pick < 92) begin
            c.opcode = OP_CLEAR;
        end else begin
            c.opcode = OP_UNUSED;
        end
        return c;
    endfunction

    task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_item(t_item c, bit typed, t_result want);
        t_result predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_opcode      <= c.opcode;
        i_start_x     <= c.start_x;
        i_start_y     <= c.start_y;
        i_end_x       <= c.end_x;
        i_end_y       <= c.end_y;
        i_erase       <= c.erase;
        i_read_page   <= c.read_page;
        i_read_column <= c.read_column;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = execute_page_cmd(c);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_flip(bit v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        flip_shadow = v;
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing outstanding", o_read_data, 8'd0);
            end else begin
                oldest = pending_results.pop_front();
                if (o_read_data !== oldest.read_data)
                    flag_mismatch("read_data", o_read_data, oldest.read_data);
                if (o_pixels_drawn !== oldest.pixels_drawn)
                    flag_mismatch("pixels_drawn", o_pixels_drawn, oldest.pixels_drawn);
            end
        end
    end

    // Bound any stretch without a transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        foreach (shadow_store[p, q]) shadow_store[p][q] = '0;
        flip_shadow = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the power-up sweep of the store has finished
        do @(posedge i_clk); while (!o_in_ready);

        send_idle_pct = 30;
        recv_idle_pct = 57;
        write_flip(1'b0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        write_flip(1'b1);
        repeat (RANDOM_PER_PHASE) send_item(random_cmd(), 1'b0, '0);
        drain_results();

        send_idle_pct = 57;
        recv_idle_pct = 30;
        write_flip(1'b0);
        repeat (RANDOM_PER_PHASE) send_item(random_cmd(), 1'b0, '0);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_flip(1'b1);
        repeat (RANDOM_PER_PHASE) send_item(random_cmd(), 1'b0, '0);
        drain_results();

        // allow for a stray result beyond the last expected one
        repeat (150) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
